>>> src/sdf_pkg.sv
// Shared constants and types for the signed decimal formatter.
`default_nettype none
package sdf_pkg;

  localparam int unsigned VALUE_WIDTH = 64;
  // Decimal places needed for 2^VALUE_WIDTH - 1, using 1233/4096 as log10(2).
  localparam int unsigned DIGITS  = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int unsigned BCD_W   = DIGITS * 4;
  localparam int unsigned NDIG_W  = $clog2(DIGITS + 1);
  localparam int unsigned CNT_W   = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

  localparam logic [5:0] CH_MINUS = 6'd45;
  localparam logic [1:0] CH_DIGIT_HI = 2'b11;  // '0' is 6'b110000
  localparam logic [3:0] DAB_LIMIT = 4'd5;
  localparam logic [3:0] DAB_ADD   = 4'd3;

  typedef logic [VALUE_WIDTH-1:0] mag_t;
  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic start;
    logic pop;
  } conv_ctrl_t;

  typedef struct packed {
    logic   ready;
    digit_t digit;
    logic   final_digit;
  } conv_stat_t;

endpackage
`default_nettype wire

>>> src/sdf_bin2bcd.sv
// Bit-serial binary to BCD converter with leading-zero removal and digit pop.
`default_nettype none
module sdf_bin2bcd (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire sdf_pkg::conv_ctrl_t ctrl_i,
  input  wire sdf_pkg::mag_t       mag_i,
  output sdf_pkg::conv_stat_t  stat_o
);
  import sdf_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_CONV, C_SKIP, C_READY} cstate_e;

  cstate_e           state_q;
  mag_t              mag_q;
  logic [BCD_W-1:0]  bcd_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [NDIG_W-1:0] ndig_q;

  logic [BCD_W-1:0]  bcd_dab;
  logic [BCD_W-1:0]  bcd_digit_shift;
  digit_t            top_digit;
  logic              one_left;

  // Add three to every place of five or more before the shift.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] >= DAB_LIMIT) begin
        bcd_dab[i*4 +: 4] = bcd_q[i*4 +: 4] + DAB_ADD;
      end else begin
        bcd_dab[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  assign bcd_digit_shift = {bcd_q[BCD_W-5:0], 4'd0};
  assign top_digit       = bcd_q[BCD_W-1 -: 4];
  assign one_left        = (ndig_q == NDIG_W'(1));

  assign stat_o.ready       = (state_q == C_READY);
  assign stat_o.digit       = top_digit;
  assign stat_o.final_digit = one_left;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      mag_q   <= '0;
      bcd_q   <= '0;
      cnt_q   <= '0;
      ndig_q  <= '0;
    end else begin
      case (state_q)
        C_IDLE: begin
          if (ctrl_i.start) begin
            mag_q   <= mag_i;
            bcd_q   <= '0;
            cnt_q   <= CNT_W'(VALUE_WIDTH - 1);
            state_q <= C_CONV;
          end
        end
        C_CONV: begin
          bcd_q <= {bcd_dab[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
          mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) begin
            ndig_q  <= NDIG_W'(DIGITS);
            state_q <= C_SKIP;
          end
        end
        C_SKIP: begin
          if (top_digit == '0 && !one_left) begin
            bcd_q  <= bcd_digit_shift;
            ndig_q <= ndig_q - NDIG_W'(1);
          end else begin
            state_q <= C_READY;
          end
        end
        C_READY: begin
          if (ctrl_i.pop) begin
            bcd_q  <= bcd_digit_shift;
            ndig_q <= ndig_q - NDIG_W'(1);
            if (one_left) begin
              state_q <= C_IDLE;
            end
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/signed_decimal_formatter.sv
// Top level: signed integer to decimal ASCII character stream.
// Steps: the item is taken, converted by bit-serial double dabble, and the leading zeros
// of the result are dropped; the converter then hands over, and the optional minus sign
// and the digits follow at one character per cycle while the output is not stalled.
// One item is in flight at a time; reset clears all control state and output.
`default_nettype none
module signed_decimal_formatter (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire signed [63:0] value_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic [5:0]        char_code_o,
  output logic              last_o
);
  import sdf_pkg::*;

  // The top sequences one item: wait for the converter, emit an optional
  // minus sign, then pop digits most significant first.
  typedef enum logic [1:0] {S_IDLE, S_CONV, S_SIGN, S_EMIT} state_e;

  state_e     state_q;
  logic       neg_q;
  logic       out_valid_q;
  logic [5:0] char_q;
  logic       last_q;

  conv_ctrl_t ctrl;
  conv_stat_t stat;
  mag_t       raw;
  mag_t       mag;
  logic       in_fire;
  logic       slot_free;
  logic       char_load;

  // Only the low VALUE_WIDTH bits take part; the sign is their top bit.
  // The negation works within that width, so the most negative value
  // yields its full unsigned magnitude.
  assign raw = value_i[VALUE_WIDTH-1:0];
  assign mag = raw[VALUE_WIDTH-1] ? (~raw + mag_t'(1)) : raw;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  // The output register can take a new character when empty or draining.
  assign slot_free  = !out_valid_q || !out_stall_i;

  assign ctrl.start = in_fire;
  assign ctrl.pop   = (state_q == S_EMIT) && stat.ready && slot_free;

  // A new character enters the output register on the sign or on a digit pop.
  assign char_load  = ((state_q == S_SIGN) && slot_free) || ctrl.pop;

  sdf_bin2bcd u_bin2bcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .mag_i  (mag),
    .stat_o (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      if (char_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            neg_q   <= raw[VALUE_WIDTH-1];
            state_q <= S_CONV;
          end
        end
        S_CONV: begin
          if (stat.ready) begin
            state_q <= neg_q ? S_SIGN : S_EMIT;
          end
        end
        S_SIGN: begin
          if (slot_free) begin
            char_q      <= CH_MINUS;
            last_q      <= 1'b0;
            state_q     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (ctrl.pop) begin
            char_q      <= {CH_DIGIT_HI, stat.digit};
            last_q      <= stat.final_digit;
            if (stat.final_digit) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

  // Every character shown is a minus sign or a decimal digit.
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_code_o == CH_MINUS) ||
                    (char_code_o[5:4] == CH_DIGIT_HI && char_code_o[3:0] <= 4'd9))
    else $error("character code out of range");

  // A minus sign is never the last character of a number.
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && char_code_o == CH_MINUS) |-> !last_o)
    else $error("minus sign marked last");

  // Digits are popped only once the converter has finished.
  a_pop_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop |-> stat.ready && state_q == S_EMIT)
    else $error("digit popped before conversion done");

  // The first character after the sign state is a digit, not another sign.
  a_sign_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SIGN && slot_free) |=> state_q == S_EMIT)
    else $error("sign state did not advance to digits");

endmodule
`default_nettype wire

>>> bench/signed_decimal_formatter_tb.sv
// Testbench for the signed decimal formatter: random and directed integers, checked per character.
`default_nettype none
module signed_decimal_formatter_tb;
  import sdf_pkg::*;

  localparam int PERIOD       = 20;
  localparam int RESET_CYCLES = 4;
  localparam int N_RANDOM     = 90;
  localparam int HOLD_CYCLES  = 600;
  // A little more than one full conversion plus its twenty characters.
  localparam int DRAIN_CYCLES = 160;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam logic [5:0] CH_ZERO = 6'd48;

  // Edge values: zero, single digits, digit-count boundaries small and near the top,
  // both ends of the signed range and alternating bit patterns.
  localparam logic [63:0] EDGE_VALUES [21] = '{
    64'd0, 64'd1, -64'sd1, 64'd9, -64'sd9, 64'd10, -64'sd10, 64'd99, 64'd100,
    64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
    64'h7FFF_FFFF_FFFF_FFFE, 64'd1_000_000_000_000_000_000,
    64'd999_999_999_999_999_999, -64'sd1_000_000_000_000_000_000,
    64'd9_000_000_000_000_000_000, 64'hAAAA_AAAA_AAAA_AAAA,
    64'h5555_5555_5555_5555, 64'd12_345_678_901_234_567, -64'sd1_234_567_890
  };

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic signed [63:0] value_i     = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [5:0]         char_code_o;
  logic               last_o;

  logic [63:0] value_q [$];      // integers still to be offered
  logic [5:0]  char_exp_q [$];   // expected characters, oldest first
  logic        last_exp_q [$];   // expected end-of-number marks, same order

  int errors         = 0;
  int accepted_count = 0;
  int cycle_count    = 0;
  int hold_left      = 0;
  logic hold_done    = 1'b0;

  signed_decimal_formatter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

  always #(PERIOD / 2) clk_i = ~clk_i;

  // Appends the decimal text of one integer to the expected character stream.
  // Only the low VALUE_WIDTH bits count; the sign is the top bit of that width.
  function automatic void format_decimal(input logic [63:0] value);
    logic [63:0] wmask;
    logic [63:0] raw;
    logic [63:0] mag;
    logic        negative;
    logic [3:0]  digit_buf [20];
    int          ndig;
    // A shift by the full 64 bits gives zero, so the mask becomes all ones.
    wmask    = (64'd1 << VALUE_WIDTH) - 64'd1;
    raw      = value & wmask;
    negative = raw[VALUE_WIDTH-1];
    // The most negative value negates to itself, which read unsigned is the right magnitude.
    mag      = negative ? ((~raw + 64'd1) & wmask) : raw;
    ndig     = 0;
    do begin
      digit_buf[ndig] = 4'(mag % 64'd10);
      mag = mag / 64'd10;
      ndig++;
    end while (mag != 64'd0);
    if (negative) begin
      char_exp_q.push_back(CH_MINUS);
      last_exp_q.push_back(1'b0);
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      char_exp_q.push_back(CH_ZERO + 6'(digit_buf[i]));
      last_exp_q.push_back(i == 0);
    end
  endfunction

  // Idle length for either side: mostly none or short, now and then long,
  // with occasional runs of back-to-back activity.
  function automatic int pick_gap(inout int quiet_left);
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 6) begin
      quiet_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  // Sender: holds each item until it is taken, then waits a random gap.
  always @(posedge clk_i or negedge rst_ni) begin : sender
    logic offering;
    int   send_gap;
    int   send_quiet;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      value_i    <= '0;
      send_gap   = 0;
      send_quiet = 0;
    end else begin
      offering = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        format_decimal(value_i);
        accepted_count <= accepted_count + 1;
        offering = 1'b0;
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (value_q.size() > 0) begin
          value_i    <= value_q.pop_front();
          in_valid_i <= 1'b1;
          send_gap   = pick_gap(send_quiet);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every accepted character and stalls at random.
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    logic busy;
    int   stall_left;
    int   recv_quiet;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
      recv_quiet  = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (char_exp_q.size() == 0) begin
          $display("%0t: unexpected character: expected none, actual %0d last %0b",
                   $time, char_code_o, last_o);
          errors++;
        end else begin
          if (char_code_o !== char_exp_q[0]) begin
            $display("%0t: char_code mismatch: expected %0d, actual %0d",
                     $time, char_exp_q[0], char_code_o);
            errors++;
          end
          if (last_o !== last_exp_q[0]) begin
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, last_exp_q[0], last_o);
            errors++;
          end
          void'(char_exp_q.pop_front());
          void'(last_exp_q.pop_front());
        end
      end
      busy = stall_left > 0;
      if (busy) stall_left--;
      else stall_left = pick_gap(recv_quiet);
      out_stall_i <= busy || (hold_left > 0);
    end
  end

  // One long hold-off early in the random part, so the block backs up into its input.
  always @(posedge clk_i or negedge rst_ni) begin : hold_off
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_count == $size(EDGE_VALUES) + 3) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [63:0] v;
    logic [63:0] p;
    int          n;
    int          kind;
    foreach (EDGE_VALUES[i]) value_q.push_back(EDGE_VALUES[i]);
    // Random part: full-width noise, small numbers, values at or next to a power of
    // ten, and values of random magnitude, each of the last three with either sign.
    for (n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 3);
      case (kind)
        0: v = {$urandom, $urandom};
        1: v = 64'($urandom_range(0, 1000));
        2: begin
          p = 64'd1;
          repeat ($urandom_range(1, 18)) p = p * 64'd10;
          v = p + 64'($urandom_range(0, 2)) - 64'd1;
        end
        default: v = {$urandom, $urandom} >> $urandom_range(1, 63);
      endcase
      if (kind != 0 && $urandom_range(0, 1) == 1) v = -v;
      value_q.push_back(v);
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (value_q.size() == 0 && !in_valid_i);
    wait (char_exp_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0 && char_exp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
src/sdf_pkg.sv
src/sdf_bin2bcd.sv
src/signed_decimal_formatter.sv
bench/signed_decimal_formatter_tb.sv
